/* src/strq_pkg.sv */
// Shared definitions for the sorted table rank query core.
// Holds field widths, the default table depth and the operation codes.
// No dependencies.
package strq_pkg;

    // Field widths of the input and result transactions
    localparam int VAL_W = 32;
    localparam int OP_W  = 2;
    localparam int CNT_W = 11;

    // Default number of table entries
    localparam int DEF_DEPTH = 1024;

    // Operation codes carried by an input transaction
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

endpackage

/* src/sorted_table_rank_query_core.sv */
// Sorted table rank query core: a DEPTH-entry ascending table in one
// synchronous RAM, with a binary search sequencer and an insert shifter.
// Depends on strq_pkg.
//
// Steps, n = entries stored: a query makes at most ceil(log2(n + 1))
// search steps; an insert makes as many at most, then n - pos shift steps,
// pos = sorted position. A full-table insert is dropped; clear and an
// unused code finish without a search. Each search step and each shift
// step uses the single RAM read port. One transaction at a time.
// Reset: control state and fill count clear at once; RAM contents are left
// as they are and never read above the fill count. No clearing pass.
module sorted_table_rank_query_core #(
    parameter int DEPTH = strq_pkg::DEF_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [strq_pkg::OP_W-1:0]          i_operation,
    input  logic signed [strq_pkg::VAL_W-1:0]  i_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [strq_pkg::CNT_W-1:0]         o_count,
    output logic                               o_dropped
);
    import strq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } t_state;

    // Table RAM and its registered read data
    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] r_rd_data;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;

    // Sequencer state
    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hi, n_hi;
    logic [CW-1:0]           r_mid, n_mid;
    logic [CW-1:0]           r_pos, n_pos;
    logic [CW-1:0]           r_sidx, n_sidx;
    logic                    r_is_ins, n_is_ins;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic [CW-1:0]           r_res_count, n_res_count;
    logic                    r_res_drop, n_res_drop;
    logic                    r_out_valid, n_out_valid;
    logic [CNT_W-1:0]        r_out_count, n_out_count;
    logic                    r_out_drop, n_out_drop;

    // Search step and address helpers
    logic                    le;
    logic [CW-1:0]           s_lo, s_hi, s_mid;
    logic [CW-1:0]           cnt_m1, sidx_p1, sidx_m1, mid0;
    logic [CW+CNT_W-1:0]     res_ext;

    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_count   = r_out_count;
    assign o_dropped = r_out_drop;

    assign le      = (r_rd_data <= r_key);
    assign s_lo    = le ? (r_mid + CW'(1)) : r_lo;
    assign s_hi    = le ? r_hi : r_mid;
    assign s_mid   = s_lo + ((s_hi - s_lo) >> 1);
    assign cnt_m1  = r_count - CW'(1);
    assign sidx_p1 = r_sidx + CW'(1);
    assign sidx_m1 = r_sidx - CW'(1);
    assign mid0    = r_count >> 1;
    assign res_ext = {{CNT_W{1'b0}}, r_res_count};

    // Next state, RAM control and result selection
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_pos       = r_pos;
        n_sidx      = r_sidx;
        n_is_ins    = r_is_ins;
        n_key       = r_key;
        n_res_count = r_res_count;
        n_res_drop  = r_res_drop;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        n_out_drop  = r_out_drop;
        mem_re      = 1'b0;
        mem_raddr   = r_mid[AW-1:0];
        mem_we      = 1'b0;
        mem_waddr   = r_pos[AW-1:0];
        mem_wdata   = r_key;

        // Retire the result transaction
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key      = i_value;
                    n_res_drop = 1'b0;
                    n_lo       = '0;
                    n_hi       = r_count;
                    n_mid      = mid0;
                    n_is_ins   = 1'b0;
                    unique case (t_op'(i_operation))
                        OP_INSERT: begin
                            n_is_ins = 1'b1;
                            if (r_count == FULL_CNT) begin
                                n_res_count = r_count;
                                n_res_drop  = 1'b1;
                                n_state     = S_DONE;
                            end else if (r_count == '0) begin
                                n_pos   = '0;
                                n_state = S_PLACE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = mid0[AW-1:0];
                                n_state   = S_SEARCH;
                            end
                        end
                        OP_QUERY: begin
                            if (r_count == '0) begin
                                n_res_count = '0;
                                n_state     = S_DONE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = mid0[AW-1:0];
                                n_state   = S_SEARCH;
                            end
                        end
                        OP_CLEAR: begin
                            n_count     = '0;
                            n_res_count = '0;
                            n_state     = S_DONE;
                        end
                        default: begin
                            n_res_count = r_count;
                            n_state     = S_DONE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // Narrow the bound and issue the next probe
                if (s_lo < s_hi) begin
                    n_lo      = s_lo;
                    n_hi      = s_hi;
                    n_mid     = s_mid;
                    mem_re    = 1'b1;
                    mem_raddr = s_mid[AW-1:0];
                end else if (!r_is_ins) begin
                    n_res_count = s_lo;
                    n_state     = S_DONE;
                end else begin
                    n_pos = s_lo;
                    if (r_count > s_lo) begin
                        mem_re    = 1'b1;
                        mem_raddr = cnt_m1[AW-1:0];
                        n_sidx    = cnt_m1;
                        n_state   = S_SHIFT;
                    end else begin
                        n_state = S_PLACE;
                    end
                end
            end
            S_SHIFT: begin
                // Move the entry read last cycle up one place
                mem_we    = 1'b1;
                mem_waddr = sidx_p1[AW-1:0];
                mem_wdata = r_rd_data;
                if (r_sidx > r_pos) begin
                    mem_re    = 1'b1;
                    mem_raddr = sidx_m1[AW-1:0];
                    n_sidx    = sidx_m1;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                mem_we      = 1'b1;
                mem_waddr   = r_pos[AW-1:0];
                mem_wdata   = r_key;
                n_count     = r_count + CW'(1);
                n_res_count = r_count + CW'(1);
                n_state     = S_DONE;
            end
            S_DONE: begin
                // Hand the result over once the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_count = res_ext[CNT_W-1:0];
                    n_out_drop  = r_res_drop;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_pos       <= n_pos;
        r_sidx      <= n_sidx;
        r_is_ins    <= n_is_ins;
        r_key       <= n_key;
        r_res_count <= n_res_count;
        r_res_drop  <= n_res_drop;
        r_out_count <= n_out_count;
        r_out_drop  <= n_out_drop;
    end

    // Table RAM write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Table RAM read port, registered read data
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill count above table depth");

    a_search_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_lo < r_hi))
        else $error("search running on an empty interval");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_sidx < r_count) && (r_sidx >= r_pos))
        else $error("shift index outside the stored entries");
`endif

endmodule
